>>> hdl/udphdr_pkg.sv
// Shared types and constants for the Ethernet/IPv4/UDP header builder.
`timescale 1ns / 1ps

package udphdr_pkg;

  // Header geometry
  localparam int HDR_WORDS    = 21;
  localparam int HDR_BYTES    = 42;
  localparam int IP_UDP_BYTES = 28;
  localparam int UDP_BYTES    = 8;

  // Fixed header words
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] IP_VER_IHL    = 16'h4500;
  localparam logic [15:0] IP_TTL_PROTO  = 16'h6411;  // TTL 100, protocol 17
  localparam logic [15:0] WORD_ZERO     = 16'h0000;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOCAL_MAC = 2'd0;
  localparam logic [1:0] CFG_PEER_MAC  = 2'd1;
  localparam logic [1:0] CFG_LOCAL_IP  = 2'd2;

  // Configuration register reset values
  localparam logic [47:0] LOCAL_MAC_RESET = 48'h525400123456;
  localparam logic [47:0] PEER_MAC_RESET  = 48'h52550a000202;
  localparam logic [31:0] LOCAL_IP_RESET  = 32'h0a00020f;

  typedef struct packed {
    logic [15:0] source_port;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [15:0] payload_len;
  } req_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [47:0] peer_mac;
    logic [31:0] own_ip;
  } cfg_t;

  // Everything the serialiser needs to emit one header
  typedef struct packed {
    logic [47:0] peer_mac;
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] ip_total_len;
    logic [15:0] udp_len;
    logic [15:0] ip_csum;
    logic        too_long;
  } frame_t;

endpackage

>>> hdl/udp_frame_header_builder.sv
// Top level: configuration registers, request register and header serialiser.
`timescale 1ns / 1ps

// Each request taken on start (while busy is low) yields the 42-byte
// Ethernet/IPv4/UDP header as 21 big-endian words, one per cycle on
// result_valid, word_index 0..20, with last_word on word 20. A request whose
// frame (payload_len + 42) exceeds MAX_FRAME_BYTES gives a single beat with
// too_long and last_word set and a zero word. The receiver cannot stall:
// each beat is on the outputs for one cycle only. On an idle block a request
// passes the request, frame and output registers before its first word shows.
// The request rate is set by the serialiser issuing one word a cycle, a
// rejected request taking a single beat; one request can wait in the input
// register while the previous header is still going out. Configuration
// writes are always ready and must only be made while no header is pending.

module udp_frame_header_builder
  import udphdr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] source_port,
  input  logic [31:0] dest_ip,
  input  logic [15:0] dest_port,
  input  logic [15:0] payload_len,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // result channel
  output logic        result_valid,
  output logic [15:0] header_word,
  output logic [4:0]  word_index,
  output logic        last_word,
  output logic        too_long
);

  cfg_t        cfg;
  req_t        req;
  logic        req_valid;
  logic        ser_free;
  logic        load;
  logic        req_too_long;
  logic [16:0] frame_bytes;
  frame_t      frame;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_mac  <= LOCAL_MAC_RESET;
      cfg.peer_mac <= PEER_MAC_RESET;
      cfg.own_ip   <= LOCAL_IP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOCAL_MAC: cfg.own_mac  <= cfg_data;
        CFG_PEER_MAC:  cfg.peer_mac <= cfg_data;
        CFG_LOCAL_IP:  cfg.own_ip   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Request register, freed when the serialiser takes its frame
  assign load = req_valid && ser_free;
  assign busy = req_valid && !ser_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (start && !busy) begin
      req_valid <= 1'b1;
    end else if (load) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.source_port <= source_port;
      req.dest_ip     <= dest_ip;
      req.dest_port   <= dest_port;
      req.payload_len <= payload_len;
    end
  end

  // Frame limit check
  assign frame_bytes  = 17'(req.payload_len) + 17'(HDR_BYTES);
  assign req_too_long = frame_bytes > 17'(MAX_FRAME_BYTES);

  udphdr_csum u_csum (
    .req      (req),
    .cfg      (cfg),
    .too_long (req_too_long),
    .frame    (frame)
  );

  udphdr_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .frame        (frame),
    .free         (ser_free),
    .result_valid (result_valid),
    .header_word  (header_word),
    .word_index   (word_index),
    .last_word    (last_word),
    .too_long     (too_long)
  );

endmodule

>>> hdl/udphdr_csum.sv
// Length fields and IPv4 header checksum for one registered request.
`timescale 1ns / 1ps

module udphdr_csum
  import udphdr_pkg::*;
(
  input  req_t   req,
  input  cfg_t   cfg,
  input  logic   too_long,
  output frame_t frame
);

  logic [15:0] ip_total_len;
  logic [15:0] udp_len;
  logic [19:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // Length fields wrap at 16 bits
  assign ip_total_len = req.payload_len + 16'(IP_UDP_BYTES);
  assign udp_len      = req.payload_len + 16'(UDP_BYTES);

  // Ones'-complement sum of the IP header, checksum field as zero
  assign sum = 20'(IP_VER_IHL) + 20'(ip_total_len) + 20'(IP_TTL_PROTO)
             + 20'(cfg.own_ip[31:16]) + 20'(cfg.own_ip[15:0])
             + 20'(req.dest_ip[31:16]) + 20'(req.dest_ip[15:0]);
  assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    frame.peer_mac     = cfg.peer_mac;
    frame.own_mac      = cfg.own_mac;
    frame.own_ip       = cfg.own_ip;
    frame.dest_ip      = req.dest_ip;
    frame.source_port  = req.source_port;
    frame.dest_port    = req.dest_port;
    frame.ip_total_len = ip_total_len;
    frame.udp_len      = udp_len;
    frame.ip_csum      = ~fold2;
    frame.too_long     = too_long;
  end

endmodule

>>> hdl/udphdr_ser.sv
// Header serialiser: holds one frame and emits its words, one beat a cycle.
`timescale 1ns / 1ps

module udphdr_ser
  import udphdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  frame_t      frame,
  output logic        free,
  output logic        result_valid,
  output logic [15:0] header_word,
  output logic [4:0]  word_index,
  output logic        last_word,
  output logic        too_long
);

  frame_t      frm;
  logic        active;
  logic [4:0]  cnt;
  logic        last_issue;
  logic [15:0] words [HDR_WORDS];

  // Word table for the held frame, in frame order
  always_comb begin
    words[0]  = frm.peer_mac[47:32];
    words[1]  = frm.peer_mac[31:16];
    words[2]  = frm.peer_mac[15:0];
    words[3]  = frm.own_mac[47:32];
    words[4]  = frm.own_mac[31:16];
    words[5]  = frm.own_mac[15:0];
    words[6]  = ETH_TYPE_IPV4;
    words[7]  = IP_VER_IHL;
    words[8]  = frm.ip_total_len;
    words[9]  = WORD_ZERO;
    words[10] = WORD_ZERO;
    words[11] = IP_TTL_PROTO;
    words[12] = frm.ip_csum;
    words[13] = frm.own_ip[31:16];
    words[14] = frm.own_ip[15:0];
    words[15] = frm.dest_ip[31:16];
    words[16] = frm.dest_ip[15:0];
    words[17] = frm.source_port;
    words[18] = frm.dest_port;
    words[19] = frm.udp_len;
    words[20] = WORD_ZERO;
  end

  assign last_issue = active && (frm.too_long || cnt == 5'(HDR_WORDS - 1));
  assign free       = !active || last_issue;

  // Frame hold and word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (last_issue) begin
      active <= 1'b0;
    end else if (active) begin
      cnt <= cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frm <= frame;
    end
  end

  // Output register, one beat per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    header_word <= frm.too_long ? WORD_ZERO : words[cnt];
    word_index  <= frm.too_long ? 5'd0 : cnt;
    last_word   <= last_issue;
    too_long    <= frm.too_long;
  end

  // A new frame only replaces one that has finished
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("frame loaded while serialiser busy");

  // A full header ends on its final word
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_word && !too_long |-> word_index == 5'(HDR_WORDS - 1))
    else $error("header ended on wrong word");

  // A rejected request gives one zero beat
  a_reject: assert property (@(posedge clk) disable iff (rst)
    result_valid && too_long |-> last_word && header_word == WORD_ZERO)
    else $error("malformed reject beat");

  // Words of one header follow without gaps
  a_consecutive: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_word |=> result_valid
      && word_index == $past(word_index) + 5'd1)
    else $error("gap or skip inside header");

endmodule

>>> sim/udp_header_checker.sv
// Checker for the header builder: tracks register writes, predicts header beats, compares.
`timescale 1ns / 1ps

module udp_header_checker
  import udphdr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] source_port,
  input  logic [31:0] dest_ip,
  input  logic [15:0] dest_port,
  input  logic [15:0] payload_len,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        result_valid,
  input  logic [15:0] header_word,
  input  logic [4:0]  word_index,
  input  logic        last_word,
  input  logic        too_long,
  output int          fail_count,
  output int          pending_beats,
  output int          headers_built,
  output int          requests_rejected,
  output int          cfg_writes
);

  typedef struct packed {
    logic [15:0] hword;
    logic [4:0]  windex;
    logic        is_last;
    logic        is_reject;
  } hdr_beat_t;

  // expected beats, oldest first
  hdr_beat_t header_beats[$];
  // shadow of the address registers
  cfg_t      addr_regs;

  // Ones'-complement sum of the 20-byte IP header, checksum field as zero
  function automatic logic [15:0] ip_header_checksum(input logic [15:0] total_len,
                                                     input logic [31:0] src_ip,
                                                     input logic [31:0] dst_ip);
    int unsigned sum;
    sum = 32'h4500 + total_len + 32'h6411 + src_ip[31:16] + src_ip[15:0]
        + dst_ip[31:16] + dst_ip[15:0];
    sum = (sum & 32'hffff) + (sum >> 16);
    sum = sum + (sum >> 16);
    return ~sum[15:0];
  endfunction

  // Work out the beats one request should produce and queue them
  task automatic queue_header(input req_t rq);
    logic [15:0] w [HDR_WORDS];
    logic [15:0] total_len;
    hdr_beat_t   b;
    if (32'(rq.payload_len) + HDR_BYTES > MAX_FRAME_BYTES) begin
      b = '{hword: 16'h0000, windex: 5'd0, is_last: 1'b1, is_reject: 1'b1};
      header_beats.push_back(b);
      requests_rejected++;
      return;
    end
    total_len = rq.payload_len + 16'(IP_UDP_BYTES);
    w[0]  = addr_regs.peer_mac[47:32];
    w[1]  = addr_regs.peer_mac[31:16];
    w[2]  = addr_regs.peer_mac[15:0];
    w[3]  = addr_regs.own_mac[47:32];
    w[4]  = addr_regs.own_mac[31:16];
    w[5]  = addr_regs.own_mac[15:0];
    w[6]  = 16'h0800;
    w[7]  = 16'h4500;
    w[8]  = total_len;
    w[9]  = 16'h0000;
    w[10] = 16'h0000;
    w[11] = {8'd100, 8'd17};
    w[12] = ip_header_checksum(total_len, addr_regs.own_ip, rq.dest_ip);
    w[13] = addr_regs.own_ip[31:16];
    w[14] = addr_regs.own_ip[15:0];
    w[15] = rq.dest_ip[31:16];
    w[16] = rq.dest_ip[15:0];
    w[17] = rq.source_port;
    w[18] = rq.dest_port;
    w[19] = rq.payload_len + 16'(UDP_BYTES);
    w[20] = 16'h0000;
    for (int i = 0; i < HDR_WORDS; i++) begin
      b = '{hword: w[i], windex: 5'(i), is_last: (i == HDR_WORDS - 1), is_reject: 1'b0};
      header_beats.push_back(b);
    end
    headers_built++;
  endtask

  task automatic check_field(input string fname, input int beat_no,
                             input logic [15:0] exp_v, input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch on beat %0d, expected %h, actual %h",
               $time, fname, beat_no, exp_v, act_v);
      fail_count++;
    end
  endtask

  // All channels sampled at the rising edge, values from before the edge
  always @(posedge clk) begin
    hdr_beat_t exp_b;
    if (rst) begin
      addr_regs         = '{own_mac: 48'h525400123456, peer_mac: 48'h52550a000202,
                            own_ip: 32'h0a00020f};
      header_beats.delete();
      fail_count        = 0;
      headers_built     = 0;
      requests_rejected = 0;
      cfg_writes        = 0;
    end else begin
      // result beat against oldest expectation
      if (result_valid) begin
        if (header_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual word %h index %0d last %b too_long %b",
                   $time, header_word, word_index, last_word, too_long);
          fail_count++;
        end else begin
          exp_b = header_beats.pop_front();
          check_field("header_word", int'(exp_b.windex), exp_b.hword, header_word);
          check_field("word_index", int'(exp_b.windex), 16'(exp_b.windex),
                      16'(word_index));
          check_field("last_word", int'(exp_b.windex), 16'(exp_b.is_last),
                      16'(last_word));
          check_field("too_long", int'(exp_b.windex), 16'(exp_b.is_reject),
                      16'(too_long));
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          CFG_LOCAL_MAC: addr_regs.own_mac  = cfg_data;
          CFG_PEER_MAC:  addr_regs.peer_mac = cfg_data;
          CFG_LOCAL_IP:  addr_regs.own_ip   = cfg_data[31:0];
          default: ;
        endcase
      end
      // request taken
      if (start && !busy)
        queue_header({source_port, dest_ip, dest_port, payload_len});
    end
    pending_beats = header_beats.size();
  end

endmodule

>>> sim/tb_udp_frame_header_builder.sv
// Testbench top for the header builder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_udp_frame_header_builder;
  import udphdr_pkg::*;

  localparam int         MAX_FRAME        = 4096;
  localparam int         MAX_PLEN_OK      = MAX_FRAME - HDR_BYTES;
  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         SETTLE_CYCLES    = 8;
  localparam int         N_SETTINGS       = 6;
  localparam int         REQS_PER_SETTING = 80;
  localparam logic [1:0] CFG_UNUSED       = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] source_port;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;
  logic [15:0] payload_len;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        result_valid;
  logic [15:0] header_word;
  logic [4:0]  word_index;
  logic        last_word;
  logic        too_long;

  int fail_count;
  int pending_beats;
  int headers_built;
  int requests_rejected;
  int cfg_writes;
  int cycle_count  = 0;
  int zero_gap_run = 0;

  udp_frame_header_builder #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) i_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .source_port(source_port), .dest_ip(dest_ip),
    .dest_port(dest_port), .payload_len(payload_len),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .header_word(header_word),
    .word_index(word_index), .last_word(last_word), .too_long(too_long)
  );

  udp_header_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) i_checker (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .source_port(source_port), .dest_ip(dest_ip),
    .dest_port(dest_port), .payload_len(payload_len),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .header_word(header_word),
    .word_index(word_index), .last_word(last_word), .too_long(too_long),
    .fail_count(fail_count), .pending_beats(pending_beats),
    .headers_built(headers_built), .requests_rejected(requests_rejected),
    .cfg_writes(cfg_writes)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected", cycle_count,
               pending_beats);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One request beat, after a random gap; returns at the edge that takes it
  task automatic send_request(input logic [15:0] sp, input logic [31:0] dip,
                              input logic [15:0] dp, input logic [15:0] plen);
    int   gap;
    logic taken;
    if (zero_gap_run > 0) begin
      gap = 0;
      zero_gap_run--;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 15) == 0)
        zero_gap_run = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    source_port <= sp;
    dest_ip     <= dip;
    dest_port   <= dp;
    payload_len <= plen;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Mostly frames that fit, some near the limit, some fully random lengths
  task automatic random_request();
    int          pick;
    logic [15:0] plen;
    pick = $urandom_range(0, 9);
    if (pick < 7)
      plen = 16'($urandom_range(0, MAX_PLEN_OK));
    else if (pick == 7)
      plen = 16'($urandom_range(MAX_PLEN_OK - 4, MAX_PLEN_OK + 4));
    else
      plen = 16'($urandom);
    send_request(16'($urandom), $urandom, 16'($urandom), plen);
  endtask

  // Register write beat; caller drops cfg_valid after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic load_setting(input logic [47:0] lmac, input logic [47:0] pmac,
                              input logic [47:0] lip);
    write_reg(CFG_LOCAL_MAC, lmac);
    write_reg(CFG_PEER_MAC, pmac);
    write_reg(CFG_LOCAL_IP, lip);
    cfg_valid <= 1'b0;
  endtask

  // Stop requests and wait until every expected beat has been seen
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending_beats != 0 || busy);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    source_port <= '0;
    dest_ip     <= '0;
    dest_port   <= '0;
    payload_len <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_LOCAL_MAC;
    cfg_data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // write to the unused index must leave the reset values alone
    write_reg(CFG_UNUSED, 48'hffff_ffff_ffff);
    cfg_valid <= 1'b0;

    // directed: field extremes, length limit either side, wrap of len+42
    send_request(16'h0000, 32'h0000_0000, 16'h0000, 16'd0);
    send_request(16'hffff, 32'hffff_ffff, 16'hffff, 16'(MAX_PLEN_OK));
    send_request(16'hffff, 32'hffff_ffff, 16'hffff, 16'(MAX_PLEN_OK + 1));
    send_request(16'h1234, 32'h0a00_0202, 16'h0035, 16'(MAX_PLEN_OK));
    send_request(16'h0000, 32'h0000_0000, 16'h0000, 16'hffff);
    send_request(16'h0001, 32'h7f00_0001, 16'h0001, 16'hffd6);
    send_request(16'h8000, 32'h8000_0000, 16'h8000, 16'hffe4);
    send_request(16'haaaa, 32'haaaa_aaaa, 16'haaaa, 16'h0aaa);
    send_request(16'h5555, 32'h5555_5555, 16'h5555, 16'h0555);
    send_request(16'hffff, 32'hffff_0000, 16'h0000, 16'd1);
    send_request(16'h0000, 32'h0000_ffff, 16'hffff, 16'(MAX_PLEN_OK - 1));
    send_request(16'hc000, 32'hf5ff_fdff, 16'h0800, 16'h8000);
    send_request(16'h4000, 32'hc0a8_0101, 16'h0044, 16'h0800);
    send_request(16'h0043, 32'hffff_ffff, 16'h0044, 16'h0fff);
    send_request(16'h0043, 32'hffff_ffff, 16'h0044, 16'd0);

    // random requests over several register settings, extremes first
    for (int s = 0; s < N_SETTINGS; s++) begin
      if (s > 0) begin
        wait_idle();
        case (s)
          1:       load_setting(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff);
          2:       load_setting(48'h0, 48'h0, 48'h0);
          default: load_setting(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                48'({$urandom, $urandom}));
        endcase
      end
      repeat (REQS_PER_SETTING) random_request();
    end

    wait_idle();
    $display("Covered %0d requests: %0d full headers and %0d over-length rejections",
             headers_built + requests_rejected, headers_built, requests_rejected);
    $display("Register writes: %0d over %0d settings, unused index included",
             cfg_writes, N_SETTINGS);
    if (fail_count == 0 && pending_beats == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
